>>> hw/rtl/ipv4dq_pkg.sv
// types and character constants shared by the dotted quad parser modules
package ipv4dq_pkg;

	typedef struct packed {
		logic [7:0] char_in;
		logic       first;
	} char_item_t;

	typedef struct packed {
		logic        valid_res;
		logic [31:0] address;
	} res_item_t;

	// one step of the parse as seen by the output stage
	typedef struct packed {
		logic      emit;
		res_item_t res;
	} parse_step_t;

	localparam logic [7:0] CHAR_NUL   = 8'h00;
	localparam logic [7:0] CHAR_TAB   = 8'h09;
	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_DOT   = 8'h2E;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;

	localparam logic [11:0] PART_MAX  = 12'd255;
	localparam logic [1:0]  DOTS_FULL = 2'd3;

endpackage

>>> hw/rtl/ipv4_dotted_quad_parser.sv
// Dotted quad address parser: takes one ASCII character per transfer, with first marking
// the start of a string, and gives one result per string holding a valid flag and the
// 32-bit address (first part in the top byte, zero when rejected). A character is taken
// every cycle unless the input stalls; it is held in the input register, where the
// per-character update (multiply by ten, add, compare against 255) runs; the result for
// the terminating character is loaded from there into the result register once that is
// free, which sets res_valid. Characters after the terminator make no result until the
// next first flag. The input stalls only while a result waits in the result register and
// the held character would produce another.
module ipv4_dotted_quad_parser (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   char_valid,
	output logic                   char_stall,
	input  ipv4dq_pkg::char_item_t char_data,
	output logic                   res_valid,
	input  logic                   res_stall,
	output ipv4dq_pkg::res_item_t  res_data
);

	logic                    valid_s1;
	ipv4dq_pkg::char_item_t  item_s1;
	logic                    take;
	logic                    out_free;
	ipv4dq_pkg::parse_step_t step;

	ipv4dq_in_reg u_in_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_data  (char_data),
		.take       (take),
		.valid_s1   (valid_s1),
		.item_s1    (item_s1)
	);

	ipv4dq_parse u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.out_free (out_free),
		.take     (take),
		.step     (step)
	);

	ipv4dq_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.step      (step),
		.out_free  (out_free),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

endmodule

>>> hw/rtl/ipv4dq_in_reg.sv
// input register stage for incoming characters
module ipv4dq_in_reg (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    char_valid,
	output logic                    char_stall,
	input  ipv4dq_pkg::char_item_t  char_data,
	input  logic                    take,
	output logic                    valid_s1,
	output ipv4dq_pkg::char_item_t  item_s1
);

	logic load;

	assign char_stall = valid_s1 && !take;
	assign load       = char_valid && !char_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= char_data;
		end
	end

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !take |=> valid_s1 && $stable(item_s1))
		else $error("held character lost or changed");

endmodule

>>> hw/rtl/ipv4dq_parse.sv
// parse state and per-character update logic
module ipv4dq_parse (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    valid_s1,
	input  ipv4dq_pkg::char_item_t  item_s1,
	input  logic                    out_free,
	output logic                    take,
	output ipv4dq_pkg::parse_step_t step
);

	logic [7:0]  part_value_q;
	logic        part_overflow_q;
	logic [1:0]  dot_count_q;
	logic [23:0] done_parts_q;
	logic        finished_q;

	logic [7:0]  pv;
	logic        ov;
	logic [1:0]  dc;
	logic [23:0] dp;
	logic        fin;
	logic [7:0]  c;
	logic [11:0] acc;
	logic        is_digit;
	logic        is_end_ok;

	logic [7:0]  part_value_d;
	logic        part_overflow_d;
	logic [1:0]  dot_count_d;
	logic [23:0] done_parts_d;
	logic        finished_d;

	assign c = item_s1.char_in;

	always_comb begin
		// a first flag clears the parse before this character is looked at
		pv  = item_s1.first ? 8'd0  : part_value_q;
		ov  = item_s1.first ? 1'b0  : part_overflow_q;
		dc  = item_s1.first ? 2'd0  : dot_count_q;
		dp  = item_s1.first ? 24'd0 : done_parts_q;
		fin = item_s1.first ? 1'b0  : finished_q;

		is_digit  = (c >= ipv4dq_pkg::CHAR_ZERO) && (c <= ipv4dq_pkg::CHAR_NINE);
		is_end_ok = c inside {ipv4dq_pkg::CHAR_NUL, ipv4dq_pkg::CHAR_SPACE,
			[ipv4dq_pkg::CHAR_TAB:ipv4dq_pkg::CHAR_CR]};
		// times ten as two shifted adds
		acc = {1'b0, pv, 3'b000} + {3'b000, pv, 1'b0}
			+ {4'd0, c - ipv4dq_pkg::CHAR_ZERO};

		part_value_d    = pv;
		part_overflow_d = ov;
		dot_count_d     = dc;
		done_parts_d    = dp;
		finished_d      = fin;
		step            = '0;

		if (!fin) begin
			if (is_digit) begin
				part_value_d    = acc[7:0];
				part_overflow_d = ov || (acc > ipv4dq_pkg::PART_MAX);
			end else if (c == ipv4dq_pkg::CHAR_DOT) begin
				if (dc == ipv4dq_pkg::DOTS_FULL || ov) begin
					step.emit  = 1'b1;
					finished_d = 1'b1;
				end else begin
					done_parts_d    = {dp[15:0], pv};
					dot_count_d     = dc + 2'd1;
					part_value_d    = 8'd0;
					part_overflow_d = 1'b0;
				end
			end else begin
				step.emit  = 1'b1;
				finished_d = 1'b1;
				if (dc == ipv4dq_pkg::DOTS_FULL && !ov && is_end_ok) begin
					step.res.valid_res = 1'b1;
					step.res.address   = {dp, pv};
				end
			end
		end
	end

	assign take = valid_s1 && (!step.emit || out_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			part_value_q    <= 8'd0;
			part_overflow_q <= 1'b0;
			dot_count_q     <= 2'd0;
			done_parts_q    <= 24'd0;
			finished_q      <= 1'b1;
		end else if (take) begin
			part_value_q    <= part_value_d;
			part_overflow_q <= part_overflow_d;
			dot_count_q     <= dot_count_d;
			done_parts_q    <= done_parts_d;
			finished_q      <= finished_d;
		end
	end

	a_emit_finishes: assert property (@(posedge clk) disable iff (!arst_n)
		take && step.emit |=> finished_q)
		else $error("parse not closed after result");

	a_no_emit_when_done: assert property (@(posedge clk) disable iff (!arst_n)
		finished_q && !item_s1.first |-> !step.emit)
		else $error("result produced after end of string");

endmodule

>>> hw/rtl/ipv4dq_out_reg.sv
// result register toward the consumer
module ipv4dq_out_reg (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    take,
	input  ipv4dq_pkg::parse_step_t step,
	output logic                    out_free,
	output logic                    res_valid,
	input  logic                    res_stall,
	output ipv4dq_pkg::res_item_t   res_data
);

	logic load;

	assign out_free = !res_valid || !res_stall;
	assign load     = take && step.emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (load) begin
			res_valid <= 1'b1;
		end else if (!res_stall) begin
			res_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_data <= step.res;
		end
	end

	a_zero_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_data.valid_res |-> res_data.address == 32'd0)
		else $error("rejected address not zero");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |-> !load)
		else $error("pending result overwritten");

endmodule
